// ===== rtl/mqtt_rx_pkg.sv =====
// ----------------------------------------------------------------------------
// mqtt_rx_pkg
// Shared types and codes of the MQTT receive packet parser: parse phases,
// result kinds, status codes, drain reasons and configuration defaults.
// ----------------------------------------------------------------------------
package mqtt_rx_pkg;

	// Fixed header length field: at most this many base-128 bytes.
	localparam int MAX_LEN_BYTES_DEF = 4;

	// Packet type nibble of PUBLISH.
	localparam logic [3:0] TYPE_PUBLISH = 4'd3;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_MAX_PUBLISH_BODY = 2'd0;
	localparam logic [1:0] REG_TOPIC_LIMIT      = 2'd1;
	localparam logic [1:0] REG_PAYLOAD_LIMIT    = 2'd2;

	// Register values after reset.
	localparam logic [15:0] MAX_PUBLISH_BODY_RST = 16'd256;
	localparam logic [15:0] TOPIC_LIMIT_RST      = 16'd63;
	localparam logic [15:0] PAYLOAD_LIMIT_RST    = 16'd255;

	// Header byte masks.
	localparam logic [7:0] LEN_VALUE_MASK = 8'h7F;
	localparam logic [7:0] LEN_CONT_MASK  = 8'h80;

	// Result kinds.
	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_TOPIC   = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_PROGRESS  = 3'd0;
	localparam logic [2:0] ST_PUB_DONE  = 3'd1;
	localparam logic [2:0] ST_OTHER     = 3'd2;
	localparam logic [2:0] ST_LARGE     = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;
	localparam logic [2:0] ST_LENERR    = 3'd5;

	// Why a packet is being drained.
	typedef enum logic [1:0] {
		DR_OTHER     = 2'd0,
		DR_LARGE     = 2'd1,
		DR_MALFORMED = 2'd2
	} drain_t;

	// Parse phases, one-hot.
	typedef enum logic [6:0] {
		PH_HDR     = 7'b0000001,
		PH_LEN     = 7'b0000010,
		PH_TLEN_HI = 7'b0000100,
		PH_TLEN_LO = 7'b0001000,
		PH_TOPIC   = 7'b0010000,
		PH_PAYLOAD = 7'b0100000,
		PH_DRAIN   = 7'b1000000
	} phase_t;

endpackage

// ===== rtl/mqtt_rx_packet_parser.sv =====
// ----------------------------------------------------------------------------
// mqtt_rx_packet_parser
// Byte-wise parser of received MQTT 3.1.1 packets: fixed header, remaining
// length, PUBLISH topic and payload bytes, end-of-packet status.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the s_axis channel, one byte per transfer.
//   Results leave on the m_axis channel: topic bytes, payload bytes and
//   status-only items; tlast marks the last result of a packet and the
//   status field then tells how the packet ended. Bytes that give no result
//   (header, length, topic length, skipped and drained bytes) are consumed
//   silently.
//   The cfg channel writes the three limit registers; it is always ready.
//   The user must write it only while no packet is being parsed; the
//   block itself does not enforce this. A transferred byte is held in the
//   input register, is parsed from there, and its result is then presented
//   from the result register. One byte per cycle is sustained while the
//   receiver takes the results, as each byte is parsed in one update.
//   When the receiver stalls, a finished result waits in the output
//   register and one more byte is held in the input register; bytes that
//   give no result are still parsed. After that s_axis_tready drops.
//   Reset returns the parser to waiting for a header byte, empties both
//   registers and loads the default limits.
// ----------------------------------------------------------------------------
module mqtt_rx_packet_parser
	import mqtt_rx_pkg::*;
#(
	parameter int MAX_LEN_BYTES = MAX_LEN_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Received byte stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] packet_type,
	                                    // [14:12] status, [15] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
	output logic        m_axis_tlast,   // packet_end
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	logic [15:0] max_publish_body_q;
	logic [15:0] topic_limit_q;
	logic [15:0] payload_limit_q;

	// Input register.
	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;

	// Parser state.
	phase_t      phase_q;
	logic [3:0]  header_type_q;
	logic [1:0]  len_idx_q;
	logic [27:0] remaining_q;
	logic [15:0] topic_len_q;
	logic [15:0] topic_seen_q;
	logic [27:0] payload_seen_q;
	drain_t      drain_q;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_data_q;
	logic [3:0]  out_type_q;
	logic        out_end_q;
	logic [2:0]  out_status_q;

	// Next state and result of the byte in the input register.
	phase_t      phase_d;
	logic [3:0]  header_type_d;
	logic [1:0]  len_idx_d;
	logic [27:0] remaining_d;
	logic [15:0] topic_len_d;
	logic [15:0] topic_seen_d;
	logic [27:0] payload_seen_d;
	drain_t      drain_d;
	logic        res_valid;
	logic [1:0]  res_kind;
	logic [7:0]  res_data;
	logic        res_end;
	logic [2:0]  res_status;

	logic        out_free;
	logic        proc;
	logic [27:0] len_part;
	logic [27:0] len_sum;
	logic [27:0] rem_dec;
	logic [15:0] topic_full;
	logic [15:0] topic_inc;
	logic [27:0] payload_inc;
	logic        body_last;
	logic        body_pass;

	assign cfg_ready = 1'b1;

	// Configuration register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_publish_body_q <= MAX_PUBLISH_BODY_RST;
			topic_limit_q      <= TOPIC_LIMIT_RST;
			payload_limit_q    <= PAYLOAD_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_PUBLISH_BODY: max_publish_body_q <= cfg_data;
				REG_TOPIC_LIMIT:      topic_limit_q      <= cfg_data;
				REG_PAYLOAD_LIMIT:    payload_limit_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held byte is parsed when its result, if any, has room to go.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign proc          = in_valid_s1 && (out_free || !res_valid);
	assign s_axis_tready = !in_valid_s1 || proc;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	// Base-128 length digit placed at its weight.
	always_comb begin
		case (len_idx_q)
			2'd0:    len_part = {21'd0, in_byte_s1[6:0]};
			2'd1:    len_part = {14'd0, in_byte_s1[6:0], 7'd0};
			2'd2:    len_part = {7'd0, in_byte_s1[6:0], 14'd0};
			default: len_part = {in_byte_s1[6:0], 21'd0};
		endcase
	end

	assign len_sum     = remaining_q + len_part;
	assign rem_dec     = remaining_q - 28'd1;
	assign topic_full  = {topic_len_q[15:8], in_byte_s1};
	assign topic_inc   = topic_seen_q + 16'd1;
	assign payload_inc = payload_seen_q + 28'd1;
	assign body_last   = (rem_dec == 28'd0);
	assign body_pass   = phase_q == PH_TOPIC ? (topic_inc <= topic_limit_q)
	                                         : (payload_inc <= {12'd0, payload_limit_q});

	// Phase machine: one byte per pass.
	always_comb begin
		phase_d        = phase_q;
		header_type_d  = header_type_q;
		len_idx_d      = len_idx_q;
		remaining_d    = remaining_q;
		topic_len_d    = topic_len_q;
		topic_seen_d   = topic_seen_q;
		payload_seen_d = payload_seen_q;
		drain_d        = drain_q;
		res_valid      = 1'b0;
		res_kind       = KIND_STATUS;
		res_data       = 8'd0;
		res_end        = 1'b1;
		res_status     = ST_PROGRESS;

		case (phase_q)
			PH_LEN: begin
				remaining_d = len_sum;
				if ((in_byte_s1 & LEN_CONT_MASK) != 8'd0) begin
					if ({1'b0, len_idx_q} + 3'd1 >= 3'(MAX_LEN_BYTES)) begin
						phase_d    = PH_HDR;
						res_valid  = 1'b1;
						res_status = ST_LENERR;
					end else begin
						len_idx_d = len_idx_q + 2'd1;
					end
				end else if (header_type_q != TYPE_PUBLISH) begin
					if (len_sum == 28'd0) begin
						phase_d    = PH_HDR;
						res_valid  = 1'b1;
						res_status = ST_OTHER;
					end else begin
						phase_d = PH_DRAIN;
						drain_d = DR_OTHER;
					end
				end else if (len_sum > {12'd0, max_publish_body_q}) begin
					phase_d = PH_DRAIN;
					drain_d = DR_LARGE;
				end else if (len_sum == 28'd0) begin
					phase_d    = PH_HDR;
					res_valid  = 1'b1;
					res_status = ST_MALFORMED;
				end else if (len_sum == 28'd1) begin
					phase_d = PH_DRAIN;
					drain_d = DR_MALFORMED;
				end else begin
					phase_d = PH_TLEN_HI;
				end
			end

			PH_TLEN_HI: begin
				topic_len_d = {in_byte_s1, 8'd0};
				remaining_d = rem_dec;
				phase_d     = PH_TLEN_LO;
			end

			PH_TLEN_LO: begin
				topic_len_d    = topic_full;
				remaining_d    = rem_dec;
				topic_seen_d   = 16'd0;
				payload_seen_d = 28'd0;
				if ({12'd0, topic_full} > rem_dec) begin
					if (body_last) begin
						phase_d    = PH_HDR;
						res_valid  = 1'b1;
						res_status = ST_MALFORMED;
					end else begin
						phase_d = PH_DRAIN;
						drain_d = DR_MALFORMED;
					end
				end else if (body_last) begin
					phase_d    = PH_HDR;
					res_valid  = 1'b1;
					res_status = ST_PUB_DONE;
				end else begin
					phase_d = (topic_full != 16'd0) ? PH_TOPIC : PH_PAYLOAD;
				end
			end

			PH_TOPIC, PH_PAYLOAD: begin
				remaining_d = rem_dec;
				if (phase_q == PH_TOPIC) begin
					topic_seen_d = topic_inc;
					if (topic_inc >= topic_len_q) begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					payload_seen_d = payload_inc;
				end
				if (body_last) begin
					phase_d = PH_HDR;
				end
				// A passed byte always gives a result; a skipped one only at the end.
				res_valid  = body_pass || body_last;
				res_end    = body_last;
				res_status = body_last ? ST_PUB_DONE : ST_PROGRESS;
				if (body_pass) begin
					res_kind = (phase_q == PH_TOPIC) ? KIND_TOPIC : KIND_PAYLOAD;
					res_data = in_byte_s1;
				end
			end

			PH_DRAIN: begin
				remaining_d = rem_dec;
				if (body_last) begin
					phase_d   = PH_HDR;
					res_valid = 1'b1;
					case (drain_q)
						DR_LARGE:     res_status = ST_LARGE;
						DR_MALFORMED: res_status = ST_MALFORMED;
						default:      res_status = ST_OTHER;
					endcase
				end
			end

			default: begin
				// Header byte: start a new packet.
				header_type_d  = in_byte_s1[7:4];
				len_idx_d      = 2'd0;
				remaining_d    = 28'd0;
				topic_len_d    = 16'd0;
				topic_seen_d   = 16'd0;
				payload_seen_d = 28'd0;
				drain_d        = DR_OTHER;
				phase_d        = PH_LEN;
			end
		endcase
	end

	// Parser state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HDR;
			header_type_q  <= 4'd0;
			len_idx_q      <= 2'd0;
			remaining_q    <= 28'd0;
			topic_len_q    <= 16'd0;
			topic_seen_q   <= 16'd0;
			payload_seen_q <= 28'd0;
			drain_q        <= DR_OTHER;
		end else if (proc) begin
			phase_q        <= phase_d;
			header_type_q  <= header_type_d;
			len_idx_q      <= len_idx_d;
			remaining_q    <= remaining_d;
			topic_len_q    <= topic_len_d;
			topic_seen_q   <= topic_seen_d;
			payload_seen_q <= payload_seen_d;
			drain_q        <= drain_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= proc && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			out_kind_q   <= res_kind;
			out_data_q   <= res_data;
			out_type_q   <= header_type_q;
			out_end_q    <= res_end;
			out_status_q <= res_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_status_q, out_type_q, out_data_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_end_q;

	// A packet end always carries a final status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (out_status_q != ST_PROGRESS))
		else $error("packet end without a final status");

	// A result that does not end a packet is a data byte in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |->
			(out_kind_q != KIND_STATUS && out_status_q == ST_PROGRESS))
		else $error("mid-packet result is not a data byte");

	// Status-only results carry a zero data byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_kind_q == KIND_STATUS) |-> (out_data_q == 8'd0))
		else $error("status-only result with data");

	// A parsed header byte always moves on to the length field.
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && phase_q == PH_HDR) |=> (phase_q == PH_LEN))
		else $error("header byte did not start the length field");

	// A byte waiting in the input register is neither lost nor changed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !proc) |=> (in_valid_s1 && $stable(in_byte_s1)))
		else $error("held input byte was overwritten");

endmodule
